@@ sv/poq_pkg.sv @@
// shared types and codes of the priority ordered queue
`default_nettype none

package poq_pkg;

  localparam int TAG_BITS   = 32;
  localparam int PRIO_BITS  = 16;
  localparam int OP_BITS    = 3;
  localparam int ST_BITS    = 3;
  localparam int COUNT_BITS = 5;

  localparam logic [OP_BITS-1:0] OP_PUSH      = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PUSH_PRIO = 3'd1;
  localparam logic [OP_BITS-1:0] OP_POP       = 3'd2;
  localparam logic [OP_BITS-1:0] OP_FIND      = 3'd3;
  localparam logic [OP_BITS-1:0] OP_REMOVE    = 3'd4;

  localparam logic [ST_BITS-1:0] ST_OK            = 3'd0;
  localparam logic [ST_BITS-1:0] ST_EMPTY         = 3'd1;
  localparam logic [ST_BITS-1:0] ST_FULL          = 3'd2;
  localparam logic [ST_BITS-1:0] ST_NOT_FOUND     = 3'd3;
  localparam logic [ST_BITS-1:0] ST_NOT_FOUND_ERR = 3'd4;

  typedef struct packed {
    logic [OP_BITS-1:0]   operation;
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] priority_req;
    logic                 strict;
  } in_item_t;

  typedef struct packed {
    logic [ST_BITS-1:0]    status;
    logic [TAG_BITS-1:0]   out_tag;
    logic [PRIO_BITS-1:0]  out_priority;
    logic                  found;
    logic [COUNT_BITS-1:0] count;
  } out_item_t;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_CMP_TAG,
    CMD_CMP_PRIO,
    CMD_PUSH_HEAD,
    CMD_PUSH_PRIO,
    CMD_POP,
    CMD_REMOVE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ sv/poq_cell.sv @@
// one queue slot: holds an entry, compares it and trades it with its neighbors
`default_nettype none

module poq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire poq_pkg::cell_ctl_t ctl,
  input  wire logic               before_hit,
  input  wire logic               prev_valid,
  input  wire poq_pkg::entry_t    prev_entry,
  input  wire logic               next_valid,
  input  wire poq_pkg::entry_t    next_entry,
  output logic                    valid,
  output poq_pkg::entry_t         entry,
  output logic                    hit
);

  logic            valid_r, valid_nxt;
  poq_pkg::entry_t entry_r, entry_nxt;
  logic            hit_r, hit_nxt;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    hit_nxt   = hit_r;
    unique case (ctl.cmd)
      poq_pkg::CMD_CMP_TAG: begin
        hit_nxt = valid_r && (entry_r.tag == ctl.entry.tag);
      end
      poq_pkg::CMD_CMP_PRIO: begin
        hit_nxt = valid_r && (entry_r.prio <= ctl.entry.prio);
      end
      poq_pkg::CMD_PUSH_HEAD: begin
        valid_nxt = prev_valid;
        entry_nxt = prev_entry;
      end
      poq_pkg::CMD_PUSH_PRIO: begin
        if (before_hit) begin
          valid_nxt = prev_valid;
          entry_nxt = prev_entry;
        end else if (hit_r || (!valid_r && prev_valid)) begin
          valid_nxt = 1'b1;
          entry_nxt = ctl.entry;
        end
      end
      poq_pkg::CMD_POP: begin
        if (valid_r && !next_valid) begin
          valid_nxt = 1'b0;
        end
      end
      poq_pkg::CMD_REMOVE: begin
        if (before_hit || hit_r) begin
          valid_nxt = next_valid;
          entry_nxt = next_entry;
        end
      end
      poq_pkg::CMD_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    entry_r <= entry_nxt;
    hit_r   <= hit_nxt;
  end

  assign valid = valid_r;
  assign entry = entry_r;
  assign hit   = hit_r;

endmodule

`default_nettype wire

@@ sv/priority_ordered_queue.sv @@
// priority ordered queue: sequencer over a row of entry cells
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall   | in_data  (poq_pkg::in_item_t)
//   out     | output    | out_valid / out_stall | out_data (poq_pkg::out_item_t)
//
// an item goes through capture, per-cell compare, apply and load result
// the apply cycle waits while the result register is full and stalled
// the next item is taken while a finished result still waits at the output
// reset empties the queue at once; entry contents are kept unreset
`default_nettype none

module priority_ordered_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire poq_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output poq_pkg::out_item_t      out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t             state_r, state_nxt;
  poq_pkg::in_item_t  req_r, req_nxt;
  poq_pkg::out_item_t out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  poq_pkg::cell_ctl_t ctl;
  poq_pkg::cell_cmd_t apply_cmd;
  poq_pkg::entry_t    req_entry;
  poq_pkg::entry_t    cell_entry [CAPACITY];
  poq_pkg::entry_t    sel_entry;
  poq_pkg::out_item_t result;
  logic [CAPACITY-1:0] valid_vec, hit_vec, before_vec, first_vec, tail_vec, sel_vec;
  logic [CNT_W-1:0]   count_after;
  logic               in_accept, apply_go, full, empty, any_hit;

  assign req_entry.tag  = req_r.tag;
  assign req_entry.prio = req_r.priority_req;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic            prev_valid, next_valid;
      poq_pkg::entry_t prev_entry, next_entry;

      if (g == 0) begin : g_head
        assign prev_valid    = 1'b1;
        assign prev_entry    = req_entry;
        assign before_vec[g] = 1'b0;
      end else begin : g_mid
        assign prev_valid    = valid_vec[g-1];
        assign prev_entry    = cell_entry[g-1];
        assign before_vec[g] = |hit_vec[g-1:0];
      end

      if (g == CAPACITY - 1) begin : g_tail
        assign next_valid = 1'b0;
        assign next_entry = cell_entry[g];
      end else begin : g_body
        assign next_valid = valid_vec[g+1];
        assign next_entry = cell_entry[g+1];
      end

      assign first_vec[g] = hit_vec[g] && !before_vec[g];
      assign tail_vec[g]  = valid_vec[g] && !next_valid;

      poq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .before_hit (before_vec[g]),
        .prev_valid (prev_valid),
        .prev_entry (prev_entry),
        .next_valid (next_valid),
        .next_entry (next_entry),
        .valid      (valid_vec[g]),
        .entry      (cell_entry[g]),
        .hit        (hit_vec[g])
      );
    end
  endgenerate

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);
  assign any_hit = |hit_vec;
  assign sel_vec = (req_r.operation == poq_pkg::OP_POP) ? tail_vec : first_vec;

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel_vec[i]) begin
        sel_entry = sel_entry | cell_entry[i];
      end
    end
  end

  // result and cell command of the apply cycle
  always_comb begin
    apply_cmd    = poq_pkg::CMD_HOLD;
    count_after  = count_r;
    result       = '0;
    case (req_r.operation) inside
      poq_pkg::OP_PUSH, poq_pkg::OP_PUSH_PRIO: begin
        if (full) begin
          result.status = poq_pkg::ST_FULL;
        end else begin
          apply_cmd   = (req_r.operation == poq_pkg::OP_PUSH) ?
                        poq_pkg::CMD_PUSH_HEAD : poq_pkg::CMD_PUSH_PRIO;
          count_after = count_r + CNT_W'(1);
        end
      end
      poq_pkg::OP_POP: begin
        if (empty) begin
          result.status = poq_pkg::ST_EMPTY;
        end else begin
          apply_cmd           = poq_pkg::CMD_POP;
          count_after         = count_r - CNT_W'(1);
          result.out_tag      = sel_entry.tag;
          result.out_priority = sel_entry.prio;
        end
      end
      poq_pkg::OP_FIND, poq_pkg::OP_REMOVE: begin
        if (any_hit) begin
          result.found        = 1'b1;
          result.out_tag      = sel_entry.tag;
          result.out_priority = sel_entry.prio;
          if (req_r.operation == poq_pkg::OP_REMOVE) begin
            apply_cmd   = poq_pkg::CMD_REMOVE;
            count_after = count_r - CNT_W'(1);
          end
        end else if (req_r.operation == poq_pkg::OP_REMOVE && req_r.strict) begin
          result.status = poq_pkg::ST_NOT_FOUND_ERR;
        end else begin
          result.status = poq_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    result.count = poq_pkg::COUNT_BITS'(count_after);
  end

  assign in_accept = in_valid && !in_stall;
  assign apply_go  = (state_r == S_APPLY) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    count_nxt     = count_r;
    ctl.cmd       = poq_pkg::CMD_HOLD;
    ctl.entry     = req_entry;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          req_nxt   = in_data;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        case (req_r.operation) inside
          poq_pkg::OP_FIND, poq_pkg::OP_REMOVE: ctl.cmd = poq_pkg::CMD_CMP_TAG;
          poq_pkg::OP_PUSH_PRIO:                ctl.cmd = poq_pkg::CMD_CMP_PRIO;
          default:                              ctl.cmd = poq_pkg::CMD_HOLD;
        endcase
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (apply_go) begin
          ctl.cmd       = apply_cmd;
          out_data_nxt  = result;
          out_valid_nxt = 1'b1;
          count_nxt     = count_after;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("occupied cells disagree with held count");

  a_apply_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    apply_go |=> out_valid_r && state_r == S_IDLE)
    else $error("apply cycle did not load a result");

  a_one_first_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPLY |-> $onehot0(first_vec))
    else $error("more than one first matching cell");

endmodule

`default_nettype wire
